/* hw/rtl/vasw_pkg.sv */
`default_nettype none

package vasw_pkg;

   localparam int VOICE_COUNT = 8;
   localparam int PAD_COUNT   = 16;

   localparam int CH_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   // The gain pipeline needs three register stages after the capture.
   localparam int GAIN_STAGES = 3;
   localparam int SCAN_CYCLES = (VOICE_COUNT > GAIN_STAGES) ? VOICE_COUNT : GAIN_STAGES;
   localparam int CNT_W       = (SCAN_CYCLES > 1) ? $clog2(SCAN_CYCLES) : 1;

   localparam int PAD_W    = 5;
   localparam int VEL_W    = 8;
   localparam int VOL_W    = 8;
   localparam int BUSY_W   = 8;
   localparam int TIME_W   = 32;
   localparam int CHAN_W   = 3;
   localparam int GAIN_W   = 8;
   localparam int MASTER_W = 8;

   localparam logic [MASTER_W-1:0] MASTER_RESET = 8'd255;
   localparam logic [PAD_W:0]      PAD_LIMIT    = (PAD_W+1)'(PAD_COUNT);

   // Two truncating divisions by 127 and 255 equal one by their product.
   localparam int GAIN_DIV = 127 * 255;
   localparam int PROD1_W  = VOL_W + VEL_W;
   localparam int PROD2_W  = PROD1_W + MASTER_W;
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = 18;
   localparam logic [RECIP_W-1:0] GAIN_RECIP = RECIP_W'((64'd1 << RECIP_SH) / GAIN_DIV);
   localparam int QUOT_W   = 10;
   localparam logic [QUOT_W-1:0]  GAIN_SAT   = QUOT_W'(255);
   localparam logic [GAIN_W-1:0]  GAIN_MAX   = 8'd255;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_PAD_RANGE  = 2'd1,
      STATUS_ZERO_VEL   = 2'd2,
      STATUS_EMPTY_PAD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_SCAN  = 2'd1,
      FSM_WRITE = 2'd2
   } fsm_type;

   typedef struct packed {
      logic             capture;
      logic             scan_en;
      logic [CNT_W-1:0] scan_idx;
      logic             commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

/* hw/rtl/vasw_ctrl.sv */
`default_nettype none

module vasw_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire vasw_pkg::dp_sts_type  sts,
   output vasw_pkg::ctrl_cmd_type     cmd
);

   vasw_pkg::fsm_type              state_ff, state_in;
   logic [vasw_pkg::CNT_W-1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vasw_pkg::FSM_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.scan_en  = 1'b0;
      cmd.scan_idx = cnt_ff;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         vasw_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = vasw_pkg::FSM_SCAN;
            end
         end
         vasw_pkg::FSM_SCAN: begin
            cmd.scan_en = 1'b1;
            if (cnt_ff == vasw_pkg::CNT_W'(vasw_pkg::SCAN_CYCLES - 1)) begin
               state_in = vasw_pkg::FSM_WRITE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         vasw_pkg::FSM_WRITE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = vasw_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = vasw_pkg::FSM_IDLE;
         end
      endcase
   end

   ap_commit_only_in_write: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == vasw_pkg::FSM_IDLE)
      else $error("Commit did not return the controller to idle.");

   ap_capture_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == vasw_pkg::FSM_SCAN) && (cnt_ff == '0))
      else $error("Scan did not start from the first voice.");

endmodule

`default_nettype wire

/* hw/rtl/vasw_dp.sv */
`default_nettype none

module vasw_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vasw_pkg::ctrl_cmd_type              cmd,
   output vasw_pkg::dp_sts_type                     sts,
   input  wire logic                                csr_we,
   input  wire logic [vasw_pkg::MASTER_W-1:0]       csr_wdata,
   input  wire logic                                req_cmd,
   input  wire logic [vasw_pkg::PAD_W-1:0]          req_pad,
   input  wire logic [vasw_pkg::VEL_W-1:0]          req_velocity,
   input  wire logic [vasw_pkg::VOL_W-1:0]          req_sample_volume,
   input  wire logic                                req_sample_loaded,
   input  wire logic [vasw_pkg::BUSY_W-1:0]         req_busy_mask,
   input  wire logic [vasw_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_accepted,
   output logic [1:0]                               rsp_status,
   output logic [vasw_pkg::CHAN_W-1:0]              rsp_channel,
   output logic                                     rsp_stolen,
   output logic [vasw_pkg::GAIN_W-1:0]              rsp_gain
);

   localparam int VC   = vasw_pkg::VOICE_COUNT;
   localparam int CW   = vasw_pkg::CH_W;
   localparam int TW   = vasw_pkg::TIME_W;
   localparam int P1W  = vasw_pkg::PROD1_W;
   localparam int P2W  = vasw_pkg::PROD2_W;
   localparam int QW   = vasw_pkg::QUOT_W;
   localparam int RPW  = P2W + vasw_pkg::RECIP_W;
   localparam logic [P2W:0] DIV_V = (P2W+1)'(vasw_pkg::GAIN_DIV);

   logic                            cmd_ff, loaded_ff;
   logic [vasw_pkg::PAD_W-1:0]      pad_ff;
   logic [vasw_pkg::VEL_W-1:0]      vel_ff;
   logic [vasw_pkg::VOL_W-1:0]      svol_ff;
   logic [vasw_pkg::BUSY_W-1:0]     busy_ff;
   logic [TW-1:0]                   now_ff;
   logic [vasw_pkg::MASTER_W-1:0]   master_ff;

   logic [vasw_pkg::PAD_W-1:0]      voice_pad_ff [VC];
   logic [vasw_pkg::PAD_W-1:0]      voice_pad_in [VC];
   logic [TW-1:0]                   voice_start_ff [VC];
   logic [TW-1:0]                   voice_start_in [VC];

   logic [TW-1:0]                   best_ff, best_in;
   logic [CW-1:0]                   best_ch_ff, best_ch_in;

   logic [P1W-1:0]                  prod1_ff;
   logic [P2W-1:0]                  prod2_ff;
   logic [QW-1:0]                   quot_ff;
   logic [RPW-1:0]                  recip_prod;
   logic [P2W:0]                    back_prod, remainder;
   logic [vasw_pkg::GAIN_W-1:0]     gain_c;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_accepted_ff, rsp_accepted_in;
   vasw_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [vasw_pkg::CHAN_W-1:0]     rsp_channel_ff, rsp_channel_in;
   logic                            rsp_stolen_ff, rsp_stolen_in;
   logic [vasw_pkg::GAIN_W-1:0]     rsp_gain_ff, rsp_gain_in;

   vasw_pkg::status_type            check_c;
   logic                            idle_found;
   logic [CW-1:0]                   idle_ch, pick_ch;
   logic [CW-1:0]                   scan_ch;
   logic                            scan_live;
   logic                            protected_c;
   logic [CW+vasw_pkg::CHAN_W-1:0]  chan_ext;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_cmd;
         pad_ff    <= req_pad;
         vel_ff    <= req_velocity;
         svol_ff   <= req_sample_volume;
         loaded_ff <= req_sample_loaded;
         busy_ff   <= req_busy_mask;
         now_ff    <= req_now_ms;
      end
      prod1_ff <= P1W'(svol_ff) * P1W'(vel_ff);
      prod2_ff <= P2W'(prod1_ff) * P2W'(master_ff);
      quot_ff  <= recip_prod[RPW-1 -: QW];
      best_ff    <= best_in;
      best_ch_ff <= best_ch_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_stolen_ff   <= rsp_stolen_in;
      rsp_gain_ff     <= rsp_gain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= vasw_pkg::MASTER_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < VC; c++) begin
            voice_pad_ff[c]   <= '0;
            voice_start_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            master_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < VC; c++) begin
            voice_pad_ff[c]   <= voice_pad_in[c];
            voice_start_ff[c] <= voice_start_in[c];
         end
      end
   end

   assign recip_prod = RPW'(prod2_ff) * RPW'(vasw_pkg::GAIN_RECIP);
   assign back_prod  = (P2W+1)'(quot_ff) * DIV_V;
   assign remainder  = (P2W+1)'(prod2_ff) - back_prod;

   always_comb begin
      if (quot_ff >= vasw_pkg::GAIN_SAT) begin
         gain_c = vasw_pkg::GAIN_MAX;
      end else begin
         gain_c = quot_ff[vasw_pkg::GAIN_W-1:0]
                + vasw_pkg::GAIN_W'(remainder >= DIV_V);
      end
   end

   always_comb begin
      if ({1'b0, pad_ff} >= vasw_pkg::PAD_LIMIT) begin
         check_c = vasw_pkg::STATUS_PAD_RANGE;
      end else if (vel_ff == '0) begin
         check_c = vasw_pkg::STATUS_ZERO_VEL;
      end else if (!loaded_ff) begin
         check_c = vasw_pkg::STATUS_EMPTY_PAD;
      end else begin
         check_c = vasw_pkg::STATUS_OK;
      end
   end

   always_comb begin
      idle_found = 1'b0;
      idle_ch    = '0;
      for (int c = VC - 1; c >= 0; c--) begin
         if ((c >= vasw_pkg::BUSY_W) || !busy_ff[c % vasw_pkg::BUSY_W]) begin
            idle_found = 1'b1;
            idle_ch    = CW'(c);
         end
      end
   end

   assign scan_ch     = cmd.scan_idx[CW-1:0];
   assign scan_live   = cmd.scan_en && (32'(cmd.scan_idx) < 32'(VC));
   assign protected_c = (voice_pad_ff[scan_ch] == '0) && (pad_ff != '0);

   always_comb begin
      best_in    = best_ff;
      best_ch_in = best_ch_ff;
      if (cmd.capture) begin
         best_in    = '1;
         best_ch_in = '0;
      end else if (scan_live && !protected_c && (voice_start_ff[scan_ch] < best_ff)) begin
         best_in    = voice_start_ff[scan_ch];
         best_ch_in = scan_ch;
      end
   end

   assign pick_ch  = idle_found ? idle_ch : best_ch_ff;
   assign chan_ext = (CW+vasw_pkg::CHAN_W)'(pick_ch);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_channel_in  = rsp_channel_ff;
      rsp_stolen_in   = rsp_stolen_ff;
      rsp_gain_in     = rsp_gain_ff;
      for (int c = 0; c < VC; c++) begin
         voice_pad_in[c]   = voice_pad_ff[c];
         voice_start_in[c] = voice_start_ff[c];
      end
      if (cmd.commit) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = 1'b0;
         rsp_status_in   = vasw_pkg::STATUS_OK;
         rsp_channel_in  = '0;
         rsp_stolen_in   = 1'b0;
         rsp_gain_in     = '0;
         if (cmd_ff) begin
            for (int c = 0; c < VC; c++) begin
               voice_pad_in[c]   = '0;
               voice_start_in[c] = '0;
            end
         end else if (check_c != vasw_pkg::STATUS_OK) begin
            rsp_status_in = check_c;
         end else begin
            rsp_accepted_in         = 1'b1;
            rsp_channel_in          = chan_ext[vasw_pkg::CHAN_W-1:0];
            rsp_stolen_in           = !idle_found;
            rsp_gain_in             = gain_c;
            voice_pad_in[pick_ch]   = pad_ff;
            voice_start_in[pick_ch] = now_ff;
         end
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_channel  = rsp_channel_ff;
   assign rsp_stolen   = rsp_stolen_ff;
   assign rsp_gain     = rsp_gain_ff;

   ap_remainder_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (quot_ff < vasw_pkg::GAIN_SAT) |-> remainder < (DIV_V << 1))
      else $error("Gain quotient estimate is off by more than one.");

   ap_steal_scanned: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !cmd_ff && !idle_found && (best_ff != '1)
      |-> !((voice_pad_ff[best_ch_ff] == '0) && (pad_ff != '0)))
      else $error("A protected voice was chosen for stealing.");

endmodule

`default_nettype wire

/* hw/rtl/voice_allocator_with_stealing_core.sv */
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  cmd, pad, velocity, sample_volume,
//                                           sample_loaded, busy_mask, now_ms
// rsp_      out        rsp_valid/rsp_ready  accepted, status, channel, stolen, gain
// csr_      in         csr_we               master_volume on csr_wdata
//
// The search for the oldest voice reads one voice per cycle and lasts at least as long as
// the gain pipeline; then the write state writes the result and the voice state once the
// output is free. One item is in work at a time; the next is taken in the cycle after the
// result is written, while the result may still wait for rsp_ready.
// A stalled output holds the controller in its write state until the result is taken.
// Reset clears all voices and sets the master volume to 255.

module voice_allocator_with_stealing_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [vasw_pkg::MASTER_W-1:0]   csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [vasw_pkg::PAD_W-1:0]      req_pad,
   input  wire logic [vasw_pkg::VEL_W-1:0]      req_velocity,
   input  wire logic [vasw_pkg::VOL_W-1:0]      req_sample_volume,
   input  wire logic                            req_sample_loaded,
   input  wire logic [vasw_pkg::BUSY_W-1:0]     req_busy_mask,
   input  wire logic [vasw_pkg::TIME_W-1:0]     req_now_ms,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_accepted,
   output logic [1:0]                           rsp_status,
   output logic [vasw_pkg::CHAN_W-1:0]          rsp_channel,
   output logic                                 rsp_stolen,
   output logic [vasw_pkg::GAIN_W-1:0]          rsp_gain
);

   vasw_pkg::ctrl_cmd_type   cmd;
   vasw_pkg::dp_sts_type     sts;

   vasw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vasw_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_cmd           (req_cmd),
      .req_pad           (req_pad),
      .req_velocity      (req_velocity),
      .req_sample_volume (req_sample_volume),
      .req_sample_loaded (req_sample_loaded),
      .req_busy_mask     (req_busy_mask),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_status        (rsp_status),
      .rsp_channel       (rsp_channel),
      .rsp_stolen        (rsp_stolen),
      .rsp_gain          (rsp_gain)
   );

   ap_accept_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second item was taken while one was in work.");

   ap_accepted_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_status == vasw_pkg::STATUS_OK)
      else $error("An assigned voice carries a reject status.");

   ap_stolen_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_stolen && (rsp_channel == '0) && (rsp_gain == '0))
      else $error("A rejected item carries voice fields.");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam logic CMD_TRIGGER = 1'b0;
   localparam logic CMD_PANIC   = 1'b1;
   localparam int VELOCITY_FULL = 127;
   localparam int LEVEL_FULL    = 255;
   localparam int PHASE_ITEMS   = 300;
   localparam int PHASE_COUNT   = 6;

   typedef struct packed {
      logic                        cmd;
      logic [vasw_pkg::PAD_W-1:0]  pad;
      logic [vasw_pkg::VEL_W-1:0]  velocity;
      logic [vasw_pkg::VOL_W-1:0]  sample_volume;
      logic                        sample_loaded;
      logic [vasw_pkg::BUSY_W-1:0] busy_mask;
      logic [vasw_pkg::TIME_W-1:0] now_ms;
   } pad_trigger_type;

   typedef struct packed {
      logic                        accepted;
      vasw_pkg::status_type        status;
      logic [vasw_pkg::CHAN_W-1:0] channel;
      logic                        stolen;
      logic [vasw_pkg::GAIN_W-1:0] gain;
   } voice_reply_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [vasw_pkg::MASTER_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = CMD_TRIGGER;
   logic [vasw_pkg::PAD_W-1:0] req_pad = '0;
   logic [vasw_pkg::VEL_W-1:0] req_velocity = '0;
   logic [vasw_pkg::VOL_W-1:0] req_sample_volume = '0;
   logic req_sample_loaded = 1'b0;
   logic [vasw_pkg::BUSY_W-1:0] req_busy_mask = '0;
   logic [vasw_pkg::TIME_W-1:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted;
   logic [1:0] rsp_status;
   logic [vasw_pkg::CHAN_W-1:0] rsp_channel;
   logic rsp_stolen;
   logic [vasw_pkg::GAIN_W-1:0] rsp_gain;

   pad_trigger_type trigger_backlog[$];
   voice_reply_type expected_replies[$];

   logic [vasw_pkg::PAD_W-1:0]    voice_pad_tbl[vasw_pkg::VOICE_COUNT];
   logic [vasw_pkg::TIME_W-1:0]   voice_start[vasw_pkg::VOICE_COUNT];
   logic [vasw_pkg::MASTER_W-1:0] master_level = vasw_pkg::MASTER_RESET;

   int queued_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int stolen_count = 0;
   int rejected_count = 0;
   int fail_count = 0;
   bit req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   logic [15:0] stall_pattern = '1;
   logic [5:0] stall_tick = '0;
   pad_trigger_type next_trig;
   pad_trigger_type sent_trig;
   voice_reply_type want;

   voice_allocator_with_stealing_core DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pad           (req_pad),
      .req_velocity      (req_velocity),
      .req_sample_volume (req_sample_volume),
      .req_sample_loaded (req_sample_loaded),
      .req_busy_mask     (req_busy_mask),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_status        (rsp_status),
      .rsp_channel       (rsp_channel),
      .rsp_stolen        (rsp_stolen),
      .rsp_gain          (rsp_gain)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      for (int c = 0; c < vasw_pkg::VOICE_COUNT; c++) begin
         voice_pad_tbl[c] = '0;
         voice_start[c] = '0;
      end
   end

   function automatic voice_reply_type allocate_voice(pad_trigger_type trig);
      voice_reply_type reply;
      logic [vasw_pkg::TIME_W-1:0] oldest;
      logic [31:0] product;
      logic [31:0] scaled;
      int pick;
      bit idle_found;
      reply = '{accepted: 1'b0, status: vasw_pkg::STATUS_OK, channel: '0, stolen: 1'b0,
                gain: '0};
      pick = 0;
      idle_found = 1'b0;
      if (trig.cmd == CMD_PANIC) begin
         for (int c = 0; c < vasw_pkg::VOICE_COUNT; c++) begin
            voice_pad_tbl[c] = '0;
            voice_start[c] = '0;
         end
      end else if (trig.pad >= vasw_pkg::PAD_COUNT) begin
         reply.status = vasw_pkg::STATUS_PAD_RANGE;
      end else if (trig.velocity == 0) begin
         reply.status = vasw_pkg::STATUS_ZERO_VEL;
      end else if (!trig.sample_loaded) begin
         reply.status = vasw_pkg::STATUS_EMPTY_PAD;
      end else begin
         for (int c = 0; c < vasw_pkg::VOICE_COUNT; c++) begin
            if (!idle_found && !(c < vasw_pkg::BUSY_W && trig.busy_mask[c])) begin
               pick = c;
               idle_found = 1'b1;
            end
         end
         if (!idle_found) begin
            oldest = '1;
            for (int c = 0; c < vasw_pkg::VOICE_COUNT; c++) begin
               if (!(voice_pad_tbl[c] == 0 && trig.pad != 0) && voice_start[c] < oldest) begin
                  oldest = voice_start[c];
                  pick = c;
               end
            end
         end
         voice_pad_tbl[pick] = trig.pad;
         voice_start[pick] = trig.now_ms;
         product = 32'(trig.sample_volume) * 32'(trig.velocity) * 32'(master_level);
         scaled = product / VELOCITY_FULL / LEVEL_FULL;
         reply.accepted = 1'b1;
         reply.channel = vasw_pkg::CHAN_W'(pick);
         reply.stolen = !idle_found;
         reply.gain = (scaled > 32'(vasw_pkg::GAIN_MAX)) ? vasw_pkg::GAIN_MAX
                                                          : scaled[vasw_pkg::GAIN_W-1:0];
      end
      return reply;
   endfunction

   function automatic pad_trigger_type make_trigger(int pad, int vel, int vol, bit loaded,
                                                    logic [vasw_pkg::BUSY_W-1:0] busy,
                                                    logic [vasw_pkg::TIME_W-1:0] stamp);
      pad_trigger_type trig;
      trig.cmd = CMD_TRIGGER;
      trig.pad = vasw_pkg::PAD_W'(pad);
      trig.velocity = vasw_pkg::VEL_W'(vel);
      trig.sample_volume = vasw_pkg::VOL_W'(vol);
      trig.sample_loaded = loaded;
      trig.busy_mask = busy;
      trig.now_ms = stamp;
      return trig;
   endfunction

   function automatic pad_trigger_type random_trigger();
      pad_trigger_type trig;
      int roll;
      int stamp_roll;
      roll = $urandom_range(0, 99);
      stamp_roll = $urandom_range(0, 7);
      trig.cmd = CMD_TRIGGER;
      trig.pad = vasw_pkg::PAD_W'($urandom_range(1, vasw_pkg::PAD_COUNT - 1));
      if ($urandom_range(0, 3) == 0) begin
         trig.pad = '0;
      end
      trig.velocity = ($urandom_range(0, 7) == 0) ? vasw_pkg::VEL_W'(255)
                                                  : vasw_pkg::VEL_W'($urandom_range(1, 255));
      trig.sample_volume = vasw_pkg::VOL_W'($urandom);
      trig.sample_loaded = 1'b1;
      trig.busy_mask = ($urandom_range(0, 1) == 0) ? '1 : vasw_pkg::BUSY_W'($urandom);
      if (stamp_roll < 2) begin
         trig.now_ms = vasw_pkg::TIME_W'($urandom_range(0, 15));
      end else if (stamp_roll == 2) begin
         trig.now_ms = ($urandom_range(0, 1) == 0) ? '0 : '1;
      end else begin
         trig.now_ms = $urandom;
      end
      if (roll < 4) begin
         trig.cmd = CMD_PANIC;
         trig.pad = vasw_pkg::PAD_W'($urandom);
      end else if (roll < 14) begin
         trig.pad = vasw_pkg::PAD_W'($urandom);
         trig.velocity = ($urandom_range(0, 2) == 0) ? '0 : vasw_pkg::VEL_W'($urandom);
         trig.sample_loaded = 1'($urandom_range(0, 1));
      end
      return trig;
   endfunction

   task automatic queue_trigger(pad_trigger_type trig);
      trigger_backlog.push_back(trig);
      queued_count++;
   endtask

   task automatic set_master_volume(logic [vasw_pkg::MASTER_W-1:0] level);
      csr_wdata <= level;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      master_level = level;
   endtask

   task automatic check_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (trigger_backlog.size() != 0) begin
            next_trig = trigger_backlog.pop_front();
            req_cmd <= next_trig.cmd;
            req_pad <= next_trig.pad;
            req_velocity <= next_trig.velocity;
            req_sample_volume <= next_trig.sample_volume;
            req_sample_loaded <= next_trig.sample_loaded;
            req_busy_mask <= next_trig.busy_mask;
            req_now_ms <= next_trig.now_ms;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_tick == 0) begin
         stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      rsp_ready <= stall_pattern[stall_tick[3:0]];
      stall_tick = stall_tick + 1'b1;
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         sent_trig.cmd = req_cmd;
         sent_trig.pad = req_pad;
         sent_trig.velocity = req_velocity;
         sent_trig.sample_volume = req_sample_volume;
         sent_trig.sample_loaded = req_sample_loaded;
         sent_trig.busy_mask = req_busy_mask;
         sent_trig.now_ms = req_now_ms;
         expected_replies.push_back(allocate_voice(sent_trig));
         accepted_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            $error("Unexpected item on the result channel.");
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("channel", 32'(want.channel), 32'(rsp_channel));
            check_field("stolen", 32'(want.stolen), 32'(rsp_stolen));
            check_field("gain", 32'(want.gain), 32'(rsp_gain));
            checked_count++;
            if (want.stolen) begin
               stolen_count++;
            end
            if (want.status != vasw_pkg::STATUS_OK) begin
               rejected_count++;
            end
         end
      end
   end

   initial begin
      pad_trigger_type panic_trig;
      logic [vasw_pkg::MASTER_W-1:0] level;
      panic_trig = make_trigger(0, 0, 0, 1'b0, '0, '0);
      panic_trig.cmd = CMD_PANIC;
      queue_trigger(make_trigger(31, 0, 0, 1'b0, 8'h00, '0));
      queue_trigger(make_trigger(16, 5, 10, 1'b1, 8'h00, '0));
      queue_trigger(make_trigger(3, 0, 9, 1'b0, 8'h00, '0));
      queue_trigger(make_trigger(15, 255, 255, 1'b0, 8'h00, '0));
      queue_trigger(make_trigger(0, 1, 1, 1'b1, 8'h00, 100));
      queue_trigger(make_trigger(1, 255, 255, 1'b1, 8'h01, 50));
      queue_trigger(make_trigger(2, 200, 0, 1'b1, 8'h7F, 70));
      queue_trigger(make_trigger(5, 100, 100, 1'b1, 8'hFF, 9));
      queue_trigger(make_trigger(0, 64, 128, 1'b1, 8'hFF, '1));
      queue_trigger(panic_trig);
      queue_trigger(make_trigger(4, 127, 127, 1'b1, 8'hFF, 3));
      for (int c = 0; c < vasw_pkg::VOICE_COUNT; c++) begin
         queue_trigger(make_trigger(9, 30 * c + 1, 200, 1'b1,
                                    vasw_pkg::BUSY_W'((1 << c) - 1), '1));
      end
      queue_trigger(make_trigger(9, 255, 255, 1'b1, 8'hFF, '0));
      queue_trigger(make_trigger(0, 17, 33, 1'b1, 8'hFF, 5));
      queue_trigger(panic_trig);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         while (accepted_count != queued_count || expected_replies.size() != 0) begin
            @(negedge clock);
         end
         case (phase)
            0: level = 8'd0;
            1: level = 8'd255;
            2: level = 8'd1;
            3: level = 8'd128;
            default: level = vasw_pkg::MASTER_W'($urandom_range(0, 255));
         endcase
         set_master_volume(level);
         @(posedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_trigger(random_trigger());
         end
      end

      while (accepted_count != queued_count || expected_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (2 * (2 + vasw_pkg::VOICE_COUNT)) @(negedge clock);

      $display("Run covered %0d items over %0d master volume settings: %0d results checked,",
               accepted_count, PHASE_COUNT + 1, checked_count);
      $display("%0d of them voice steals and %0d rejected triggers.", stolen_count,
               rejected_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/vasw_pkg.sv
hw/rtl/vasw_ctrl.sv
hw/rtl/vasw_dp.sv
hw/rtl/voice_allocator_with_stealing_core.sv
tb/testbench.sv
